/* rtl/bbe_pkg.sv */
// Shared constants, a range type and a helper function of the 3x3 box blur core.
package bbe_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam int OUT_COL_W    = 10;
  localparam int OUT_ROW_W    = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd320;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Reciprocal of three, exact for every sum of three 8-bit values.
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  typedef struct packed {
    logic [OUT_COL_W-1:0] xs;
    logic [OUT_ROW_W-1:0] ys;
    logic [1:0]           kxs;
    logic [1:0]           kxe;
    logic [1:0]           kys;
    logic [1:0]           kye;
  } range_t;

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'(RECIP3);
    return p[RECIP3_SHIFT +: 8];
  endfunction

endpackage

/* rtl/box_blur_3x3_edge_repeat_core.sv */
// Top level of the 3x3 edge-repeat box blur core: configuration registers and block wiring.
// Path: a result passes the front-end stage register, the window queue and the back-end
// pipeline registers. Throughput: one pixel and one result per cycle while neither side stalls;
// the last column of a row yields up to 3 results, absorbed by a 4-entry window queue, while
// in the last row each pixel yields up to 3 (9 at the last pixel), so the input side stalls there.
// Reset: synchronous; clears counters, window, queue and pipeline, sets 640x320, keeps line store.
module box_blur_3x3_edge_repeat_core #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = bbe_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bbe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bbe_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0 up: chan0_in, chan1_in, ... one byte per channel.
  input  logic [8*CHANNELS-1:0]          s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: chan0_out.. (8 bits each), out_col (10), out_row (16), zero pad.
  output logic [((8*CHANNELS+bbe_pkg::OUT_COL_W+bbe_pkg::OUT_ROW_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int PIX_W   = 8 * CHANNELS;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = $bits(bbe_pkg::range_t) + 9 * PIX_W;
  localparam int OUT_W   = ((PIX_W + bbe_pkg::OUT_COL_W + bbe_pkg::OUT_ROW_W + 7) / 8) * 8;

  logic [bbe_pkg::CFG_WIDTH_W-1:0]  image_width;
  logic [bbe_pkg::CFG_HEIGHT_W-1:0] image_height;
  logic                             cfg_write;
  logic [COL_W-1:0]                 w_m1;
  logic [bbe_pkg::OUT_ROW_W-1:0]    h_m1;

  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_din, q_dout;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bbe_pkg::WIDTH_RESET;
      image_height <= bbe_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        bbe_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[bbe_pkg::CFG_WIDTH_W-1:0];
        bbe_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[bbe_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bbe_pkg::REG_IMAGE_WIDTH:  prdata = bbe_pkg::APB_DATA_W'(image_width);
      bbe_pkg::REG_IMAGE_HEIGHT: prdata = bbe_pkg::APB_DATA_W'(image_height);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width == '0) begin
      w_m1 = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(image_width - 11'd1);
    end
    h_m1 = (image_height == '0) ? '0 : image_height - 16'd1;
  end

  bbe_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_write),
    .w_m1     (w_m1),
    .h_m1     (h_m1),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_pix   (s_axis_tdata),
    .q_ready  (!q_full),
    .q_push   (q_push),
    .q_entry  (q_din)
  );

  bbe_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (bbe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  bbe_back #(
    .CHANNELS (CHANNELS),
    .OUT_W    (OUT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_dout),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

/* rtl/bbe_front.sv */
// Front end: pixel acceptance, line store, column window and output range classification.
module bbe_front #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = bbe_pkg::CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]           w_m1,
  input  logic [bbe_pkg::OUT_ROW_W-1:0]          h_m1,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [8*CHANNELS-1:0]                  in_pix,
  input  logic                                   q_ready,
  output logic                                   q_push,
  output logic [$bits(bbe_pkg::range_t)+72*CHANNELS-1:0] q_entry
);

  localparam int PIX_W = 8 * CHANNELS;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = bbe_pkg::OUT_ROW_W;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic [COL_W-1:0]   col_count;
  logic [ROW_W-1:0]   row_count;
  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pix;
  logic [COL_W-1:0]   s1_cx;
  logic [ROW_W-1:0]   s1_cy;
  logic [2*PIX_W-1:0] rd_word;
  logic               byp;
  logic [2*PIX_W-1:0] byp_word;
  logic [3*PIX_W-1:0] win0;
  logic [3*PIX_W-1:0] win1;

  logic [2*PIX_W-1:0] cur_word;
  logic [PIX_W-1:0]   newer;
  logic [PIX_W-1:0]   older;
  logic [3*PIX_W-1:0] col2;
  logic               in_fire;
  logic               s1_adv;
  logic               emit;
  logic               col_last, col_ge2, row_last, row_ge2;
  logic [COL_W-1:0]   xs_c;
  logic [31:0]        xs_wide;
  bbe_pkg::range_t    rng;

  assign cur_word = byp ? byp_word : rd_word;
  assign newer    = cur_word[2*PIX_W-1:PIX_W];
  assign older    = cur_word[PIX_W-1:0];
  assign col2     = {s1_pix, newer, older};

  always_comb begin
    col_last = (s1_cx == w_m1);
    col_ge2  = (s1_cx >= COL_W'(2));
    row_last = (s1_cy == h_m1);
    row_ge2  = (s1_cy >= ROW_W'(2));
    emit     = (col_last || col_ge2) && (row_last || row_ge2);
    xs_c     = col_ge2 ? s1_cx - COL_W'(2) : '0;
    xs_wide  = 32'(xs_c);
    rng.xs   = xs_wide[bbe_pkg::OUT_COL_W-1:0];
    rng.ys   = row_ge2 ? s1_cy - ROW_W'(2) : '0;
    if (col_last) begin
      rng.kxs = col_ge2 ? 2'd0 : (s1_cx[0] ? 2'd1 : 2'd2);
      rng.kxe = 2'd2;
    end else begin
      rng.kxs = 2'd0;
      rng.kxe = 2'd0;
    end
    if (row_last) begin
      rng.kys = row_ge2 ? 2'd0 : (s1_cy[0] ? 2'd1 : 2'd2);
      rng.kye = 2'd2;
    end else begin
      rng.kys = 2'd0;
      rng.kye = 2'd0;
    end
  end

  assign s1_adv   = s1_valid && (q_ready || !emit);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = s1_valid && emit && q_ready;
  assign q_entry  = {rng, col2, win1, win0};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
      win0      <= '0;
      win1      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        if (col_count == w_m1) begin
          col_count <= '0;
          row_count <= (row_count == h_m1) ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        win0 <= win1;
        win1 <= col2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix   <= in_pix;
      s1_cx    <= col_count;
      s1_cy    <= row_count;
      rd_word  <= line_mem[col_count];
      byp      <= s1_adv && (s1_cx == col_count);
      byp_word <= {s1_pix, newer};
    end
    if (s1_adv) begin
      line_mem[s1_cx] <= {s1_pix, newer};
    end
  end

endmodule

/* rtl/bbe_queue.sv */
// Short register queue that carries classified windows from the front end to the back end.
module bbe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bbe_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/bbe_back.sv */
// Back end: walks the outputs of each window and computes them in a two-stage blur pipeline.
module bbe_back #(
  parameter int CHANNELS = bbe_pkg::CHANNELS_DEF,
  parameter int OUT_W    = 56
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_valid,
  output logic                                          q_pop,
  input  logic [$bits(bbe_pkg::range_t)+72*CHANNELS-1:0] q_entry,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [OUT_W-1:0]                              out_data,
  output logic                                          out_last
);

  localparam int PIX_W  = 8 * CHANNELS;
  localparam int GRID_W = 9 * PIX_W;
  localparam int COL_W  = bbe_pkg::OUT_COL_W;
  localparam int ROW_W  = bbe_pkg::OUT_ROW_W;

  bbe_pkg::range_t    rng;
  logic [GRID_W-1:0]  grid;
  logic [1:0]         xoff, yoff;
  logic [1:0]         kx, ky;
  logic               last_x, last_y, issue;
  logic               a_ready, b_ready;
  logic [3*PIX_W-1:0] h_div;

  logic               a_valid;
  logic [3*PIX_W-1:0] a_h;
  logic [COL_W-1:0]   a_col;
  logic [ROW_W-1:0]   a_row;
  logic               a_last;
  logic [PIX_W-1:0]   v_div;

  logic [PIX_W-1:0]   b_chan;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;

  assign rng    = q_entry[GRID_W +: $bits(bbe_pkg::range_t)];
  assign grid   = q_entry[GRID_W-1:0];
  assign kx     = rng.kxs + xoff;
  assign ky     = rng.kys + yoff;
  assign last_x = (kx == rng.kxe);
  assign last_y = (ky == rng.kye);

  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign issue   = q_valid && a_ready;
  assign q_pop   = issue && last_x && last_y;

  always_comb begin
    logic [2:0] tr, tc;
    logic [1:0] rr, kk;
    logic [9:0] hs;
    int         idx;
    tr    = '0;
    tc    = '0;
    rr    = '0;
    kk    = '0;
    hs    = '0;
    idx   = 0;
    h_div = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int dy = 0; dy < 3; dy++) begin
        tr = {1'b0, ky} + 3'(dy);
        rr = (tr > 3'd2) ? 2'd2 : tr[1:0];
        hs = '0;
        for (int dx = 0; dx < 3; dx++) begin
          tc  = {1'b0, kx} + 3'(dx);
          kk  = (tc > 3'd2) ? 2'd2 : tc[1:0];
          idx = int'(kk) * 3 + int'(rr);
          hs  = hs + 10'(grid[idx*PIX_W + c*8 +: 8]);
        end
        h_div[(c*3 + dy)*8 +: 8] = bbe_pkg::div3(hs);
      end
    end
  end

  always_comb begin
    logic [9:0] vs;
    vs    = '0;
    v_div = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      vs = 10'(a_h[(c*3)*8 +: 8]) + 10'(a_h[(c*3+1)*8 +: 8]) + 10'(a_h[(c*3+2)*8 +: 8]);
      v_div[c*8 +: 8] = bbe_pkg::div3(vs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xoff      <= '0;
      yoff      <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        if (last_x) begin
          xoff <= '0;
          yoff <= last_y ? 2'd0 : yoff + 2'd1;
        end else begin
          xoff <= xoff + 2'd1;
        end
      end
      if (a_ready) begin
        a_valid <= issue;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_h    <= h_div;
      a_col  <= rng.xs + COL_W'(xoff);
      a_row  <= rng.ys + ROW_W'(yoff);
      a_last <= last_x && last_y;
    end
    if (b_ready && a_valid) begin
      b_chan   <= v_div;
      b_col    <= a_col;
      b_row    <= a_row;
      out_last <= a_last;
    end
  end

  assign out_data = OUT_W'({b_row, b_col, b_chan});

endmodule

/* bench/box_blur_3x3_edge_repeat_core_chk.sv */
`timescale 1ns / 1ps
// Checker for the 3x3 box blur core: it predicts every blurred pixel and compares the output stream.
module box_blur_3x3_edge_repeat_core_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [bbe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bbe_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // Fields from bit 0 up: chan0_in, chan1_in, chan2_in.
  input  logic [23:0]                    s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: chan0_out, chan1_out, chan2_out, out_col, out_row, zero pad.
  input  logic [55:0]                    m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             mismatch_count,
  output int                             pending_count
);
  import bbe_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int NCH   = CHANNELS_DEF;

  typedef struct packed {
    logic [NCH-1:0][7:0]  chan;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } blur_px_t;

  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  logic [8*NCH-1:0]        line_mem [0:2*MAX_W-1];
  logic [8*NCH-1:0]        win_cols [0:1][0:2];
  int unsigned             col_pos;
  int unsigned             row_pos;
  blur_px_t                blurred_px_q [$];
  int                      errs;

  task automatic restart_frame();
    int j;
    col_pos = 0;
    row_pos = 0;
    for (j = 0; j < 3; j++) begin
      win_cols[0][j] = '0;
      win_cols[1][j] = '0;
    end
  endtask

  task automatic predict_blur(input logic [8*NCH-1:0] px);
    int unsigned w, h, cx, cy, xs, xe, ys, ye, ox, oy, rx, ry, hsum, vsum, bo, bp;
    int          c, dx, dy, j;
    logic [8*NCH-1:0] grid [0:2][0:2];
    blur_px_t    res;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    cx = (col_pos >= w) ? w - 1 : col_pos;
    cy = row_pos;
    bo = cy % 2;
    bp = (cy + 1) % 2;
    grid[2][0] = line_mem[bo*MAX_W + cx];
    grid[2][1] = line_mem[bp*MAX_W + cx];
    grid[2][2] = px;
    line_mem[bo*MAX_W + cx] = px;
    for (j = 0; j < 3; j++) begin
      grid[0][j] = win_cols[0][j];
      grid[1][j] = win_cols[1][j];
      win_cols[0][j] = win_cols[1][j];
      win_cols[1][j] = grid[2][j];
    end
    // An edge pixel closes every window that reaches past the edge as well.
    if (cx == w - 1) begin
      xs = (cx >= 2) ? cx - 2 : 0;
      xe = cx;
    end else if (cx >= 2) begin
      xs = cx - 2;
      xe = xs;
    end else begin
      xs = 1;
      xe = 0;
    end
    if (cy == h - 1) begin
      ys = (cy >= 2) ? cy - 2 : 0;
      ye = cy;
    end else if (cy >= 2) begin
      ys = cy - 2;
      ye = ys;
    end else begin
      ys = 1;
      ye = 0;
    end
    if (xs <= xe && ys <= ye) begin
      for (oy = ys; oy <= ye; oy++) begin
        for (ox = xs; ox <= xe; ox++) begin
          for (c = 0; c < NCH; c++) begin
            vsum = 0;
            for (dy = 0; dy < 3; dy++) begin
              ry = oy + dy;
              if (ry > h - 1) ry = h - 1;
              hsum = 0;
              for (dx = 0; dx < 3; dx++) begin
                rx = ox + dx;
                if (rx > w - 1) rx = w - 1;
                hsum += grid[rx + 2 - cx][ry + 2 - cy][8*c +: 8];
              end
              vsum += hsum / 3;
            end
            res.chan[c] = 8'(vsum / 3);
          end
          res.col  = OUT_COL_W'(ox);
          res.row  = OUT_ROW_W'(oy);
          res.last = (ox == xe) && (oy == ye);
          blurred_px_q.insert(blurred_px_q.size(), res);
        end
      end
    end
    cx++;
    if (cx >= w) begin
      cx = 0;
      cy++;
      if (cy >= h) cy = 0;
    end
    col_pos = cx;
    row_pos = cy;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
      errs++;
    end
  endtask

  task automatic compare_output();
    blur_px_t want;
    int       c;
    if (blurred_px_q.size() == 0) begin
      $error("unexpected output transaction at col %0d row %0d",
             m_axis_tdata[8*NCH +: OUT_COL_W], m_axis_tdata[8*NCH+OUT_COL_W +: OUT_ROW_W]);
      errs++;
    end else begin
      want = blurred_px_q.pop_front();
      for (c = 0; c < NCH; c++)
        check_field($sformatf("chan%0d_out", c), want.chan[c], m_axis_tdata[8*c +: 8]);
      check_field("out_col", want.col, m_axis_tdata[8*NCH +: OUT_COL_W]);
      check_field("out_row", want.row, m_axis_tdata[8*NCH+OUT_COL_W +: OUT_ROW_W]);
      check_field("run_last", want.last, m_axis_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      restart_frame();
      blurred_px_q.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_ADDR_W-1] == REG_IMAGE_WIDTH)
          cfg_width = pwdata[CFG_WIDTH_W-1:0];
        else
          cfg_height = pwdata[CFG_HEIGHT_W-1:0];
        restart_frame();
      end
      if (s_axis_tvalid && s_axis_tready) predict_blur(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_output();
    end
    mismatch_count <= errs;
    pending_count  <= blurred_px_q.size();
  end

endmodule

/* bench/box_blur_3x3_edge_repeat_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the 3x3 box blur core: clock, reset, stimulus, watchdog and verdict.
module box_blur_3x3_edge_repeat_core_tb;
  import bbe_pkg::*;

  localparam int SETTLE_CYCLES  = 10;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH  = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = {REG_IMAGE_HEIGHT, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // Fields from bit 0 up: chan0_in, chan1_in, chan2_in.
  logic [23:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // Fields from bit 0 up: chan0_out, chan1_out, chan2_out, out_col, out_row, zero pad.
  logic [55:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  int mismatch_count;
  int pending_count;
  int quiet_cycles;
  int hold_left;
  bit idle_en;
  bit long_hold_req;

  box_blur_3x3_edge_repeat_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  box_blur_3x3_edge_repeat_core_chk blur_chk (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: random stall bursts plus one long hold that backs the block up.
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && idle_en && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 6);
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic configure(input int w, input int h);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(ADDR_WIDTH, APB_DATA_W'(w));
    apb_write(ADDR_HEIGHT, APB_DATA_W'(h));
  endtask

  task automatic send_pixel(input logic [23:0] px);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(input int count);
    int          i;
    logic [23:0] px;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       px = 24'h000000;
        1:       px = 24'hFFFFFF;
        default: px = 24'($urandom);
      endcase
      send_pixel(px);
    end
  endtask

  initial begin
    int i;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame that closes all nine windows on its last pixel.
    configure(3, 3);
    for (i = 0; i < 9; i++)
      send_pixel({(i[2] ? 8'hFF : 8'h00), (i[1] ? 8'hFF : 8'h00), (i[0] ? 8'hFF : 8'h00)});
    configure(1, 1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h7F80FF);
    send_pixel(24'h01FE80);
    // Zero sizes act as one; an oversized width saturates.
    configure(0, 0);
    send_random(2);
    configure(2047, 1);
    send_random(6);

    configure(4, 3);
    send_random(24);
    configure(5, 4);
    send_random(10);
    wait_results();
    send_random(10);
    configure(1024, 1);
    long_hold_req = 1'b1;
    send_random(30);
    configure(1, 65535);
    send_random(20);
    configure(7, 5);
    send_random(25);
    configure(2, 65535);
    send_random(20);
    configure(3, 2);
    send_random(12);
    idle_en = 1'b0;
    configure(6, 3);
    send_random(18);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/bbe_pkg.sv
rtl/bbe_front.sv
rtl/bbe_queue.sv
rtl/bbe_back.sv
rtl/box_blur_3x3_edge_repeat_core.sv
bench/box_blur_3x3_edge_repeat_core_chk.sv
bench/box_blur_3x3_edge_repeat_core_tb.sv
